[src/sat_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the summed-area table block.
// No dependencies; every other file of the block except sat_ram imports this package.
package sat_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int SUM_W     = 44;
	localparam int ELEM_W    = 32;
	localparam int POS_W     = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int STAT_W    = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic                     cmd;
		logic signed [ELEM_W-1:0] elem_value;
		logic [POS_W-1:0]         top_row;
		logic [POS_W-1:0]         left_col;
		logic [POS_W-1:0]         bottom_row;
		logic [POS_W-1:0]         right_col;
	} item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] region_sum;
		logic [STAT_W-1:0]       status;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the accepted item
		logic rd_en;    // read one table term
		logic row_lo;   // term row: low corner minus one, else high corner
		logic col_lo;   // term column: low corner minus one, else high corner
		logic negate;   // subtract the term
		logic wr_en;    // store the finished entry and advance the load position
		logic emit;     // present the result
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic query;    // the item at the input is a query
		logic err;      // that query fails with a status code
	} ctrl_stat_t;

endpackage

[src/summed_area_table_range_sum_top.sv]
`timescale 1ns / 1ps
// Top level of the summed-area table range-sum block: controller plus datapath.
// Depends on sat_pkg, sat_ctrl and sat_dp (which holds sat_ram).
//
//  channel   ports                               direction  handshake
//  item      start, busy, item                   in         start && !busy
//  result    done, result                        out        done, one cycle
//  config    cfg_we, cfg_index, cfg_wdata        in         cfg_we
//
// Sequence per item, from acceptance to the next acceptance:
//   load: three table reads, one add step, one write, all on the one RAM port
//   query in range: four table reads, one add step, result stage
//   failed query: result stage only; done rises the cycle after that stage.
// The single-port table RAM, with registered read data, sets this sequence.
// Reset clears the registers to 64 rows and columns, the load position and the
// table complete flag; the table contents stay undefined until loaded.
// Results are strobed for one cycle and the receiver cannot stall them.
module summed_area_table_range_sum_top #(
	parameter int MAX_ROWS = sat_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = sat_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sat_pkg::item_t                item,
	output logic                          busy,
	output logic                          done,
	output sat_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sat_pkg::CFG_W-1:0]     cfg_wdata
);
	import sat_pkg::*;

	ctrl_cmd_t  cmd;   // sequencing commands toward the datapath
	ctrl_stat_t stat;  // item kind and query status toward the controller

	// sequence reads, write and result for each accepted item
	sat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// hold the table, the load position and the accumulator
	sat_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule

[src/sat_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module sat_ram #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 4096
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[src/sat_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the summed-area table block: orders table reads, write and result.
// Depends on sat_pkg.
module sat_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sat_pkg::ctrl_stat_t stat,
	output logic                busy,
	output sat_pkg::ctrl_cmd_t  cmd
);
	import sat_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD0  = 8'b0000_0010,
		S_RD1  = 8'b0000_0100,
		S_RD2  = 8'b0000_1000,
		S_RD3  = 8'b0001_0000,
		S_LAST = 8'b0010_0000,
		S_WR   = 8'b0100_0000,
		S_EMIT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   is_query_q;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!stat.query) begin
						state_d = S_RD1;
					end else if (stat.err) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_RD0;
					end
				end
			end
			S_RD0:   state_d = S_RD1;
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_RD3;
			S_RD3:   state_d = S_LAST;
			S_LAST:  state_d = is_query_q ? S_EMIT : S_WR;
			S_WR:    state_d = S_IDLE;
			S_EMIT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// term selection: query adds the outer corners and subtracts the side ones,
	// load adds the entries above and left and subtracts the one above-left
	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		case (state_q)
			S_RD0: begin
				cmd.rd_en = 1'b1;
			end
			S_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.row_lo = !is_query_q;
				cmd.col_lo = is_query_q;
				cmd.negate = is_query_q;
			end
			S_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.row_lo = is_query_q;
				cmd.col_lo = !is_query_q;
				cmd.negate = is_query_q;
			end
			S_RD3: begin
				cmd.rd_en  = 1'b1;
				cmd.row_lo = 1'b1;
				cmd.col_lo = 1'b1;
				cmd.negate = !is_query_q;
			end
			S_WR:    cmd.wr_en = 1'b1;
			S_EMIT:  cmd.emit  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			is_query_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				is_query_q <= stat.query;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not make the block busy");

	a_load_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> is_query_q)
		else $error("load reached the result state");
`endif

endmodule

[src/sat_dp.sv]
`timescale 1ns / 1ps
// Datapath of the summed-area table block: registers, load position, table RAM,
// term accumulator and result register. Depends on sat_pkg and sat_ram.
module sat_dp #(
	parameter int MAX_ROWS = sat_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = sat_pkg::MAX_COLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sat_pkg::item_t                  item,
	input  sat_pkg::ctrl_cmd_t              cmd,
	output sat_pkg::ctrl_stat_t             stat,
	input  logic                            cfg_we,
	input  logic [sat_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sat_pkg::CFG_W-1:0]       cfg_wdata,
	output logic                            done,
	output sat_pkg::result_t                result
);
	import sat_pkg::*;

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0]    rows_q, cols_q, eff_rows, eff_cols;
	logic [RW-1:0]       load_row_q, row_hi_q, row_lo_q, term_row;
	logic [CW-1:0]       load_col_q, col_hi_q, col_lo_q, term_col;
	logic                ready_q;
	logic [SUM_W-1:0]    acc_q, rdata;
	logic [STAT_W-1:0]   stat_q;
	logic                term_vld_s1, border_s1, neg_s1;
	logic                border, range_bad, last_col, last_row;
	logic [AW-1:0]       rd_addr, wr_addr, addr;
	logic                done_q;
	result_t             result_q;

	// out-of-range register values: zero acts as one, above the maximum acts as it
	assign eff_rows = (rows_q == '0) ? CFG_W'(1) :
		(32'(rows_q) > 32'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_q;
	assign eff_cols = (cols_q == '0) ? CFG_W'(1) :
		(32'(cols_q) > 32'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_q;

	assign range_bad = (item.top_row > item.bottom_row) || (item.left_col > item.right_col)
		|| (CFG_W'(item.bottom_row) >= eff_rows) || (CFG_W'(item.right_col) >= eff_cols);

	assign stat.query = (item.cmd == CMD_QUERY);
	assign stat.err   = !ready_q || range_bad;

	// low corner terms step back one row or column; stepping off the edge is the
	// zero border, which is not stored
	assign term_row = cmd.row_lo ? (row_lo_q - RW'(1)) : row_hi_q;
	assign term_col = cmd.col_lo ? (col_lo_q - CW'(1)) : col_hi_q;
	assign border   = (cmd.row_lo && (row_lo_q == '0)) || (cmd.col_lo && (col_lo_q == '0));

	assign rd_addr = AW'(32'(term_row) * 32'(MAX_COLS) + 32'(term_col));
	assign wr_addr = AW'(32'(row_hi_q) * 32'(MAX_COLS) + 32'(col_hi_q));
	assign addr    = cmd.wr_en ? wr_addr : rd_addr;

	sat_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (cmd.rd_en || cmd.wr_en),
		.we    (cmd.wr_en),
		.addr  (addr),
		.wdata (acc_q),
		.rdata (rdata)
	);

	assign last_col = (32'(load_col_q) + 32'd1) >= 32'(eff_cols);
	assign last_row = (32'(load_row_q) + 32'd1) >= 32'(eff_rows);

	// control state: registers, load position, table complete flag, strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= CFG_RESET;
			cols_q      <= CFG_RESET;
			load_row_q  <= '0;
			load_col_q  <= '0;
			ready_q     <= 1'b0;
			term_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			term_vld_s1 <= cmd.rd_en;
			done_q      <= cmd.emit;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS: rows_q <= cfg_wdata;
					CFG_COLS: cols_q <= cfg_wdata;
					default:  ;
				endcase
				load_row_q <= '0;
				load_col_q <= '0;
				ready_q    <= 1'b0;
			end else if (cmd.capture && (item.cmd == CMD_LOAD)) begin
				// position is already back at the start once the table is full
				ready_q <= 1'b0;
			end else if (cmd.wr_en) begin
				if (last_col) begin
					load_col_q <= '0;
					if (last_row) begin
						load_row_q <= '0;
						ready_q    <= 1'b1;
					end else begin
						load_row_q <= load_row_q + RW'(1);
					end
				end else begin
					load_col_q <= load_col_q + CW'(1);
				end
			end
		end
	end

	// payload: item operands, accumulator, term stage, result
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			border_s1 <= border;
			neg_s1    <= cmd.negate;
		end
		if (cmd.capture) begin
			if (item.cmd == CMD_LOAD) begin
				row_hi_q <= load_row_q;
				row_lo_q <= load_row_q;
				col_hi_q <= load_col_q;
				col_lo_q <= load_col_q;
				acc_q    <= {{(SUM_W - ELEM_W){item.elem_value[ELEM_W-1]}}, item.elem_value};
				stat_q   <= STAT_OK;
			end else begin
				row_hi_q <= RW'(item.bottom_row);
				row_lo_q <= RW'(item.top_row);
				col_hi_q <= CW'(item.right_col);
				col_lo_q <= CW'(item.left_col);
				acc_q    <= '0;
				stat_q   <= !ready_q ? STAT_EMPTY : (range_bad ? STAT_RANGE : STAT_OK);
			end
		end else if (term_vld_s1 && !border_s1) begin
			acc_q <= neg_s1 ? (acc_q - rdata) : (acc_q + rdata);
		end
		if (cmd.emit) begin
			result_q.region_sum <= acc_q;
			result_q.status     <= stat_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (result_q.status != STAT_OK)) |-> (result_q.region_sum == '0))
		else $error("failed query carries a nonzero sum");

	a_wr_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !term_vld_s1)
		else $error("entry written before its last term was added");
`endif

endmodule
